/* rtl/chgs_pkg.sv */
// Shared types and constants of the convex hull block.
package chgs_pkg;

    localparam int HULL_COUNT_BITS = 7;

    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
        logic dist_lt;
    } cross_res_t;

endpackage

/* rtl/chgs_point_if.sv */
// Request channel carrying one input point.
interface chgs_point_if #(parameter int COORD_BITS = 24);

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);

endinterface

/* rtl/chgs_hull_if.sv */
// Request channel carrying one hull vertex.
interface chgs_hull_if #(parameter int COORD_BITS = 24);
    import chgs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         last_vertex;
    logic [HULL_COUNT_BITS-1:0]   hull_count;
    logic                         overflowed;

    modport source (output valid, output hull_x, output hull_y, output last_vertex,
                    output hull_count, output overflowed, input ready);
    modport sink (input valid, input hull_x, input hull_y, input last_vertex,
                  input hull_count, input overflowed, output ready);

endinterface

/* rtl/convex_hull_graham_scan.sv */
// Top level: point store, angle sort, hull scan and vertex output.
// An unmarked point is taken through the duplicate sweep of the point store.
// A marked point then runs the hull: a sweep for the start point, an insertion sort,
// the ray and scan passes, and the emission of the vertices, which waits on hull.ready,
// all through the single read port of each memory.
// Reset clears the control state, the point count and the overflow flag; the memories are
// not cleared, and nothing is read from them before it has been written.
module convex_hull_graham_scan #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    chgs_point_if.sink  points,
    chgs_hull_if.source hull
);
    import chgs_pkg::*;

    localparam int IW        = $clog2(MAX_POINTS);
    localparam int CNTW      = IW + 1;
    localparam int CW        = COORD_BITS;
    localparam int IDX_DEPTH = 2 << IW;
    localparam logic [CNTW-1:0] N_C = CNTW'(MAX_POINTS);

    typedef enum logic [4:0] {
        L_IDLE, L_DUP, L_INS, H_START, H_FS,
        S_NEXT_I, S_RDA, S_J, S_RB1, S_RB2, S_CW,
        C_COL, C_COL_R, C_F_R, C_L_R,
        SC_I, SC_SKIP_R, SC_POP, SC_POP_R, SC_PUSH0, SC_PUSH1,
        G0, G1, G2, G3, G4, G5,
        E_INIT, E_IDX, E_PTA, E_PTD
    } state_t;

    typedef enum logic [2:0] {PH_N, PH_S, PH_F, PH_H, PH_L} phase_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    phase_t ph_reg, ph_next;

    logic [CNTW-1:0] total_reg, total_next;
    logic            ovf_reg, ovf_next;
    logic            dup_reg, dup_next;
    logic            chk_reg, chk_next;
    logic [CNTW-1:0] i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [CNTW-1:0] f_reg, f_next, l_reg, l_next, top_reg, top_next;
    logic [CNTW-1:0] k_reg, k_next, e_reg, e_next, cnt_reg, cnt_next;
    logic [CNTW-1:0] fend_reg, fend_next;
    logic [IW-1:0]   s_reg, s_next, bidx_reg, bidx_next;
    logic [IW:0]     kp_reg, kp_next, ka_reg, ka_next, kb_reg, kb_next;

    logic signed [CW-1:0] inx_reg, inx_next, iny_reg, iny_next;
    logic                 inl_reg, inl_next;
    logic signed [CW-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [CW-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [CW-1:0] bx_reg, bx_next, by_reg, by_next;

    logic                       hv_reg, hv_next, hlast_reg, hlast_next, hovf_reg, hovf_next;
    logic signed [CW-1:0]       hx_reg, hx_next, hy_reg, hy_next;
    logic [HULL_COUNT_BITS-1:0] hcnt_reg, hcnt_next;

    logic [2*CW-1:0] pts_mem [MAX_POINTS];
    logic [2*CW-1:0] pts_rd_reg;
    logic            pts_we, pts_re;
    logic [IW-1:0]   pts_waddr, pts_raddr;
    logic [2*CW-1:0] pts_wdata;

    logic [IW-1:0]   idx_mem [IDX_DEPTH];
    logic [IW-1:0]   idx_rd_reg;
    logic            idx_we, idx_re;
    logic [IW:0]     idx_waddr, idx_raddr;
    logic [IW-1:0]   idx_wdata;

    logic       cr_start;
    cross_res_t cr_res;

    logic signed [CW-1:0] rx, ry;
    logic [CNTW-1:0]      prev_i;
    logic                 last_v;

    function automatic logic [IW:0] ao_a(input logic [CNTW-1:0] k);
        return {1'b0, k[IW-1:0]};
    endfunction

    function automatic logic [IW:0] hs_a(input logic [CNTW-1:0] k);
        return {1'b1, k[IW-1:0]};
    endfunction

    assign rx     = $signed(pts_rd_reg[CW-1:0]);
    assign ry     = $signed(pts_rd_reg[2*CW-1:CW]);
    assign prev_i = i_reg - CNTW'(1);
    assign last_v = (e_reg + CNTW'(1)) == cnt_reg;

    chgs_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cr_start),
        .px    (px_reg),
        .py    (py_reg),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .bx    (bx_reg),
        .by    (by_reg),
        .res   (cr_res)
    );

    always_ff @(posedge clk)
    begin
        if (pts_we)
        begin
            pts_mem[pts_waddr] <= pts_wdata;
        end
        if (pts_re)
        begin
            pts_rd_reg <= pts_mem[pts_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (idx_we)
        begin
            idx_mem[idx_waddr] <= idx_wdata;
        end
        if (idx_re)
        begin
            idx_rd_reg <= idx_mem[idx_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ph_next    = ph_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        dup_next   = dup_reg;
        chk_next   = chk_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        f_next     = f_reg;
        l_next     = l_reg;
        top_next   = top_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        cnt_next   = cnt_reg;
        fend_next  = fend_reg;
        s_next     = s_reg;
        bidx_next  = bidx_reg;
        kp_next    = kp_reg;
        ka_next    = ka_reg;
        kb_next    = kb_reg;
        inx_next   = inx_reg;
        iny_next   = iny_reg;
        inl_next   = inl_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        hv_next    = hv_reg && !hull.ready;
        hx_next    = hx_reg;
        hy_next    = hy_reg;
        hlast_next = hlast_reg;
        hcnt_next  = hcnt_reg;
        hovf_next  = hovf_reg;
        pts_we     = 1'b0;
        pts_re     = 1'b0;
        pts_waddr  = total_reg[IW-1:0];
        pts_raddr  = i_reg[IW-1:0];
        pts_wdata  = {iny_reg, inx_reg};
        idx_we     = 1'b0;
        idx_re     = 1'b0;
        idx_waddr  = ao_a(j_reg);
        idx_raddr  = kp_reg;
        idx_wdata  = i_reg[IW-1:0];
        cr_start   = 1'b0;

        unique case (state_reg)
            L_IDLE:
            begin
                if (points.valid)
                begin
                    inx_next   = points.point_x;
                    iny_next   = points.point_y;
                    inl_next   = points.last_point;
                    i_next     = '0;
                    chk_next   = 1'b0;
                    dup_next   = 1'b0;
                    state_next = L_DUP;
                end
            end
            L_DUP:
            begin
                if (chk_reg && rx == inx_reg && ry == iny_reg)
                begin
                    dup_next = 1'b1;
                end
                if (i_reg < total_reg)
                begin
                    pts_re   = 1'b1;
                    i_next   = i_reg + CNTW'(1);
                    chk_next = 1'b1;
                end
                else
                begin
                    chk_next   = 1'b0;
                    state_next = L_INS;
                end
            end
            L_INS:
            begin
                if (!dup_reg)
                begin
                    if (total_reg < N_C)
                    begin
                        pts_we     = 1'b1;
                        total_next = total_reg + CNTW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = inl_reg ? H_START : L_IDLE;
            end
            H_START:
            begin
                if (total_reg == '0)
                begin
                    ovf_next   = 1'b0;
                    state_next = L_IDLE;
                end
                else if (total_reg < CNTW'(3))
                begin
                    ph_next    = PH_N;
                    k_next     = '0;
                    e_next     = '0;
                    cnt_next   = total_reg;
                    state_next = E_IDX;
                end
                else
                begin
                    i_next     = '0;
                    chk_next   = 1'b0;
                    state_next = H_FS;
                end
            end
            H_FS:
            begin
                if (chk_reg && ((i_reg == CNTW'(1)) || (ry < py_reg) ||
                                (ry == py_reg && rx < px_reg)))
                begin
                    s_next  = prev_i[IW-1:0];
                    px_next = rx;
                    py_next = ry;
                end
                if (i_reg < total_reg)
                begin
                    pts_re   = 1'b1;
                    i_next   = i_reg + CNTW'(1);
                    chk_next = 1'b1;
                end
                else
                begin
                    chk_next   = 1'b0;
                    i_next     = '0;
                    m_next     = '0;
                    state_next = S_NEXT_I;
                end
            end
            S_NEXT_I:
            begin
                if (i_reg == total_reg)
                begin
                    idx_we     = 1'b1;
                    idx_waddr  = hs_a('0);
                    idx_wdata  = s_reg;
                    state_next = C_COL;
                end
                else if (i_reg == {1'b0, s_reg})
                begin
                    i_next = i_reg + CNTW'(1);
                end
                else
                begin
                    pts_re     = 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                ax_next    = rx;
                ay_next    = ry;
                j_next     = m_reg;
                state_next = S_J;
            end
            S_J:
            begin
                if (j_reg == '0)
                begin
                    idx_we     = 1'b1;
                    m_next     = m_reg + CNTW'(1);
                    i_next     = i_reg + CNTW'(1);
                    state_next = S_NEXT_I;
                end
                else
                begin
                    idx_re     = 1'b1;
                    idx_raddr  = ao_a(j_reg - CNTW'(1));
                    state_next = S_RB1;
                end
            end
            S_RB1:
            begin
                bidx_next  = idx_rd_reg;
                pts_re     = 1'b1;
                pts_raddr  = idx_rd_reg;
                state_next = S_RB2;
            end
            S_RB2:
            begin
                bx_next    = rx;
                by_next    = ry;
                cr_start   = 1'b1;
                state_next = S_CW;
            end
            S_CW:
            begin
                if (cr_res.done)
                begin
                    idx_we = 1'b1;
                    if ((!cr_res.neg && !cr_res.zero) || (cr_res.zero && cr_res.dist_lt))
                    begin
                        idx_wdata  = bidx_reg;
                        j_next     = j_reg - CNTW'(1);
                        state_next = S_J;
                    end
                    else
                    begin
                        m_next     = m_reg + CNTW'(1);
                        i_next     = i_reg + CNTW'(1);
                        state_next = S_NEXT_I;
                    end
                end
            end
            C_COL:
            begin
                kp_next    = hs_a('0);
                ka_next    = ao_a('0);
                kb_next    = ao_a(m_reg - CNTW'(1));
                ret_next   = C_COL_R;
                state_next = G0;
            end
            C_COL_R:
            begin
                if (cr_res.zero)
                begin
                    fend_next  = m_reg;
                    top_next   = CNTW'(1);
                    l_next     = m_reg - CNTW'(1);
                    state_next = E_INIT;
                end
                else
                begin
                    f_next     = CNTW'(1);
                    ka_next    = ao_a('0);
                    kb_next    = ao_a(CNTW'(1));
                    ret_next   = C_F_R;
                    state_next = G0;
                end
            end
            C_F_R:
            begin
                if (cr_res.zero)
                begin
                    f_next     = f_reg + CNTW'(1);
                    ka_next    = ao_a(f_reg);
                    kb_next    = ao_a(f_reg + CNTW'(1));
                    state_next = G0;
                end
                else
                begin
                    l_next     = m_reg - CNTW'(1);
                    ka_next    = ao_a(m_reg - CNTW'(2));
                    kb_next    = ao_a(m_reg - CNTW'(1));
                    ret_next   = C_L_R;
                    state_next = G0;
                end
            end
            C_L_R:
            begin
                if (cr_res.zero)
                begin
                    l_next     = l_reg - CNTW'(1);
                    ka_next    = ao_a(l_reg - CNTW'(2));
                    kb_next    = ao_a(l_reg - CNTW'(1));
                    state_next = G0;
                end
                else
                begin
                    top_next   = CNTW'(1);
                    i_next     = '0;
                    state_next = SC_I;
                end
            end
            SC_I:
            begin
                if (i_reg == m_reg)
                begin
                    fend_next  = f_reg - CNTW'(1);
                    state_next = E_INIT;
                end
                else if ((i_reg + CNTW'(1)) < m_reg)
                begin
                    kp_next    = hs_a('0);
                    ka_next    = ao_a(i_reg);
                    kb_next    = ao_a(i_reg + CNTW'(1));
                    ret_next   = SC_SKIP_R;
                    state_next = G0;
                end
                else
                begin
                    state_next = SC_POP;
                end
            end
            SC_SKIP_R:
            begin
                if (cr_res.zero)
                begin
                    i_next     = i_reg + CNTW'(1);
                    state_next = SC_I;
                end
                else
                begin
                    state_next = SC_POP;
                end
            end
            SC_POP:
            begin
                if (top_reg >= CNTW'(2))
                begin
                    kp_next    = hs_a(top_reg - CNTW'(2));
                    ka_next    = hs_a(top_reg - CNTW'(1));
                    kb_next    = ao_a(i_reg);
                    ret_next   = SC_POP_R;
                    state_next = G0;
                end
                else
                begin
                    state_next = SC_PUSH0;
                end
            end
            SC_POP_R:
            begin
                if (cr_res.neg)
                begin
                    top_next   = top_reg - CNTW'(1);
                    state_next = SC_POP;
                end
                else
                begin
                    state_next = SC_PUSH0;
                end
            end
            SC_PUSH0:
            begin
                idx_re     = 1'b1;
                idx_raddr  = ao_a(i_reg);
                state_next = SC_PUSH1;
            end
            SC_PUSH1:
            begin
                idx_we     = 1'b1;
                idx_waddr  = hs_a(top_reg);
                idx_wdata  = idx_rd_reg;
                top_next   = top_reg + CNTW'(1);
                i_next     = i_reg + CNTW'(1);
                state_next = SC_I;
            end
            G0:
            begin
                idx_re     = 1'b1;
                idx_raddr  = kp_reg;
                state_next = G1;
            end
            G1:
            begin
                pts_re     = 1'b1;
                pts_raddr  = idx_rd_reg;
                idx_re     = 1'b1;
                idx_raddr  = ka_reg;
                state_next = G2;
            end
            G2:
            begin
                px_next    = rx;
                py_next    = ry;
                pts_re     = 1'b1;
                pts_raddr  = idx_rd_reg;
                idx_re     = 1'b1;
                idx_raddr  = kb_reg;
                state_next = G3;
            end
            G3:
            begin
                ax_next    = rx;
                ay_next    = ry;
                pts_re     = 1'b1;
                pts_raddr  = idx_rd_reg;
                state_next = G4;
            end
            G4:
            begin
                bx_next    = rx;
                by_next    = ry;
                cr_start   = 1'b1;
                state_next = G5;
            end
            G5:
            begin
                if (cr_res.done)
                begin
                    state_next = ret_reg;
                end
            end
            E_INIT:
            begin
                cnt_next   = fend_reg + top_reg + m_reg - CNTW'(1) - l_reg;
                ph_next    = PH_S;
                k_next     = '0;
                e_next     = '0;
                state_next = E_IDX;
            end
            E_IDX:
            begin
                unique case (ph_reg)
                    PH_N:
                    begin
                        pts_re     = 1'b1;
                        pts_raddr  = k_reg[IW-1:0];
                        state_next = E_PTD;
                    end
                    PH_S:
                    begin
                        idx_re     = 1'b1;
                        idx_raddr  = hs_a('0);
                        state_next = E_PTA;
                    end
                    PH_H:
                    begin
                        idx_re     = 1'b1;
                        idx_raddr  = hs_a(k_reg);
                        state_next = E_PTA;
                    end
                    default:
                    begin
                        idx_re     = 1'b1;
                        idx_raddr  = ao_a(k_reg);
                        state_next = E_PTA;
                    end
                endcase
            end
            E_PTA:
            begin
                pts_re     = 1'b1;
                pts_raddr  = idx_rd_reg;
                state_next = E_PTD;
            end
            E_PTD:
            begin
                if (!hv_reg || hull.ready)
                begin
                    hv_next    = 1'b1;
                    hx_next    = rx;
                    hy_next    = ry;
                    hlast_next = last_v;
                    hcnt_next  = HULL_COUNT_BITS'(cnt_reg);
                    hovf_next  = ovf_reg;
                    if (last_v)
                    begin
                        total_next = '0;
                        ovf_next   = 1'b0;
                        state_next = L_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + CNTW'(1);
                        state_next = E_IDX;
                        case (ph_reg)
                            PH_N:
                            begin
                                k_next = k_reg + CNTW'(1);
                            end
                            PH_L:
                            begin
                                k_next = k_reg - CNTW'(1);
                            end
                            PH_F:
                            begin
                                if ((k_reg + CNTW'(1)) < fend_reg)
                                begin
                                    k_next = k_reg + CNTW'(1);
                                end
                                else if (top_reg > CNTW'(1))
                                begin
                                    ph_next = PH_H;
                                    k_next  = CNTW'(1);
                                end
                                else
                                begin
                                    ph_next = PH_L;
                                    k_next  = m_reg - CNTW'(2);
                                end
                            end
                            PH_H:
                            begin
                                if ((k_reg + CNTW'(1)) < top_reg)
                                begin
                                    k_next = k_reg + CNTW'(1);
                                end
                                else
                                begin
                                    ph_next = PH_L;
                                    k_next  = m_reg - CNTW'(2);
                                end
                            end
                            default:
                            begin
                                if (fend_reg != '0)
                                begin
                                    ph_next = PH_F;
                                    k_next  = '0;
                                end
                                else if (top_reg > CNTW'(1))
                                begin
                                    ph_next = PH_H;
                                    k_next  = CNTW'(1);
                                end
                                else
                                begin
                                    ph_next = PH_L;
                                    k_next  = m_reg - CNTW'(2);
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            ret_reg   <= L_IDLE;
            ph_reg    <= PH_N;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            dup_reg   <= 1'b0;
            chk_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            m_reg     <= '0;
            f_reg     <= '0;
            l_reg     <= '0;
            top_reg   <= '0;
            k_reg     <= '0;
            e_reg     <= '0;
            cnt_reg   <= '0;
            fend_reg  <= '0;
            s_reg     <= '0;
            bidx_reg  <= '0;
            kp_reg    <= '0;
            ka_reg    <= '0;
            kb_reg    <= '0;
            inl_reg   <= 1'b0;
            hv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ph_reg    <= ph_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            dup_reg   <= dup_next;
            chk_reg   <= chk_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            f_reg     <= f_next;
            l_reg     <= l_next;
            top_reg   <= top_next;
            k_reg     <= k_next;
            e_reg     <= e_next;
            cnt_reg   <= cnt_next;
            fend_reg  <= fend_next;
            s_reg     <= s_next;
            bidx_reg  <= bidx_next;
            kp_reg    <= kp_next;
            ka_reg    <= ka_next;
            kb_reg    <= kb_next;
            inl_reg   <= inl_next;
            hv_reg    <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inx_reg   <= inx_next;
        iny_reg   <= iny_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        hx_reg    <= hx_next;
        hy_reg    <= hy_next;
        hlast_reg <= hlast_next;
        hcnt_reg  <= hcnt_next;
        hovf_reg  <= hovf_next;
    end

    assign points.ready     = state_reg == L_IDLE;
    assign hull.valid       = hv_reg;
    assign hull.hull_x      = hx_reg;
    assign hull.hull_y      = hy_reg;
    assign hull.last_vertex = hlast_reg;
    assign hull.hull_count  = hcnt_reg;
    assign hull.overflowed  = hovf_reg;

    a_load_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (points.valid && points.ready) |=> $stable(total_reg) && (state_reg == L_DUP))
        else $error("point count changed before the duplicate sweep");

    a_sort_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT_I) |->
            ((m_reg + ((i_reg > {1'b0, s_reg}) ? CNTW'(1) : CNTW'(0))) == i_reg))
        else $error("sorted list length out of step with the point index");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SC_I) |-> (top_reg <= (i_reg + CNTW'(1))))
        else $error("hull stack deeper than the points scanned");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_IDX || state_reg == E_PTA || state_reg == E_PTD) |->
            (e_reg < cnt_reg))
        else $error("vertex index beyond hull count");

endmodule

/* rtl/chgs_cross.sv */
// Staged sign of the cross product (a - p) x (b - p) with a distance tie-break, one at a time.
module chgs_cross #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    output chgs_pkg::cross_res_t         res
);
    import chgs_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic [3:0]           st_reg;
    logic                 done_reg;
    logic signed [DW-1:0] x1_reg;
    logic signed [DW-1:0] y1_reg;
    logic signed [DW-1:0] x2_reg;
    logic signed [DW-1:0] y2_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic [DW:0]          da_reg;
    logic [DW:0]          db_reg;
    logic                 lt_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    logic signed [PW:0]   diff;

    function automatic logic [DW:0] l1_dist(input logic signed [DW-1:0] u,
                                            input logic signed [DW-1:0] v);
        logic [DW-1:0] au;
        logic [DW-1:0] av;
        au = u[DW-1] ? DW'(-u) : DW'(u);
        av = v[DW-1] ? DW'(-v) : DW'(v);
        return (DW+1)'(au) + (DW+1)'(av);
    endfunction

    assign diff = (PW+1)'(p1_reg) - (PW+1)'(p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= {st_reg[2:0], start};
            done_reg <= st_reg[3];
        end
    end

    // Operands are sampled in the cycle after start.
    always_ff @(posedge clk)
    begin
        if (st_reg[0])
        begin
            x1_reg <= DW'(ax) - DW'(px);
            y1_reg <= DW'(ay) - DW'(py);
            x2_reg <= DW'(bx) - DW'(px);
            y2_reg <= DW'(by) - DW'(py);
        end
        if (st_reg[1])
        begin
            p1_reg <= PW'(x1_reg) * PW'(y2_reg);
            da_reg <= l1_dist(x1_reg, y1_reg);
            db_reg <= l1_dist(x2_reg, y2_reg);
        end
        if (st_reg[2])
        begin
            p2_reg <= PW'(x2_reg) * PW'(y1_reg);
            lt_reg <= da_reg < db_reg;
        end
        if (st_reg[3])
        begin
            neg_reg  <= diff[PW];
            zero_reg <= diff == '0;
        end
    end

    assign res = '{done: done_reg, neg: neg_reg, zero: zero_reg, dist_lt: lt_reg};

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (st_reg == '0) && !done_reg)
        else $error("cross product started while busy");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({st_reg, done_reg}))
        else $error("more than one cross product in flight");

endmodule

/* verif/tb_convex_hull_graham_scan.sv */
// Testbench of the convex hull block: directed, overflow and random point sets checked against a predictor.
module tb_convex_hull_graham_scan;
    import chgs_pkg::*;

    localparam int NPTS = 64;
    localparam int CW = 24;

    typedef struct {
        logic signed [CW-1:0]          x;
        logic signed [CW-1:0]          y;
        logic                          lst;
        logic [HULL_COUNT_BITS-1:0]    cnt;
        logic                          ovf;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    chgs_point_if #(.COORD_BITS(CW)) pts ();
    chgs_hull_if #(.COORD_BITS(CW)) hl ();

    convex_hull_graham_scan #(.MAX_POINTS(NPTS), .COORD_BITS(CW)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (pts),
        .hull   (hl)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    longint  set_x[NPTS];
    longint  set_y[NPTS];
    int      set_size;
    bit      set_ovf;
    int      ord[NPTS];
    int      stk[NPTS];
    int      hlist[NPTS];
    vertex_t hull_due[$];
    int      errors = 0;
    int      vertices_seen = 0;
    int      sets_sent = 0;
    int      items_sent = 0;
    int      burst_left = 0;
    int      rx_cycle = 0;

    task automatic report(string what, longint want, longint got);
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        errors++;
    endtask

    function automatic int cross_sgn(int p, int a, int b);
        longint c;
        c = (set_x[a] - set_x[p]) * (set_y[b] - set_y[p])
          - (set_x[b] - set_x[p]) * (set_y[a] - set_y[p]);
        return (c < 0) ? -1 : ((c > 0) ? 1 : 0);
    endfunction

    function automatic longint ray_len(int s, int a);
        longint dx;
        longint dy;
        dx = set_x[a] - set_x[s];
        dy = set_y[a] - set_y[s];
        return ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
    endfunction

    function automatic bit angle_before(int s, int a, int b);
        int c;
        c = cross_sgn(s, a, b);
        if (c != 0)
            return c > 0;
        return ray_len(s, a) < ray_len(s, b);
    endfunction

    function automatic int build_hull();
        int n;
        int s;
        int m;
        int j;
        int f;
        int l;
        int top;
        int cnt;
        n = set_size;
        s = 0;
        m = 0;
        cnt = 0;
        if (n < 3)
        begin
            for (int i = 0; i < n; i++)
                hlist[i] = i;
            return n;
        end
        for (int i = 1; i < n; i++)
            if (set_y[i] < set_y[s] || (set_y[i] == set_y[s] && set_x[i] < set_x[s]))
                s = i;
        for (int i = 0; i < n; i++)
        begin
            if (i != s)
            begin
                j = m;
                while (j > 0 && angle_before(s, i, ord[j-1]))
                begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = i;
                m++;
            end
        end
        hlist[cnt++] = s;
        if (cross_sgn(s, ord[0], ord[m-1]) == 0)
        begin
            for (int i = 0; i < m; i++)
                hlist[cnt++] = ord[i];
            return cnt;
        end
        f = 1;
        while (cross_sgn(s, ord[f-1], ord[f]) == 0)
            f++;
        l = m - 1;
        while (cross_sgn(s, ord[l-1], ord[l]) == 0)
            l--;
        stk[0] = s;
        top = 1;
        for (int i = 0; i < m; i++)
        begin
            if (!(i + 1 < m && cross_sgn(s, ord[i], ord[i+1]) == 0))
            begin
                while (top >= 2 && cross_sgn(stk[top-2], stk[top-1], ord[i]) < 0)
                    top--;
                stk[top++] = ord[i];
            end
        end
        for (int i = 0; i + 1 < f; i++)
            hlist[cnt++] = ord[i];
        for (int i = 1; i < top; i++)
            hlist[cnt++] = stk[i];
        for (int i = m - 1; i > l; i--)
            hlist[cnt++] = ord[i-1];
        return cnt;
    endfunction

    task automatic predict_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lp);
        bit      dup;
        int      cnt;
        vertex_t v;
        dup = 1'b0;
        for (int i = 0; i < set_size; i++)
            if (set_x[i] == longint'(x) && set_y[i] == longint'(y))
                dup = 1'b1;
        if (!dup)
        begin
            if (set_size < NPTS)
            begin
                set_x[set_size] = longint'(x);
                set_y[set_size] = longint'(y);
                set_size++;
            end
            else
                set_ovf = 1'b1;
        end
        if (lp)
        begin
            cnt = build_hull();
            for (int i = 0; i < cnt; i++)
            begin
                v.x = CW'(set_x[hlist[i]]);
                v.y = CW'(set_y[hlist[i]]);
                v.lst = (i + 1 == cnt);
                v.cnt = HULL_COUNT_BITS'(cnt);
                v.ovf = set_ovf;
                hull_due.insert(hull_due.size(), v);
            end
            set_size = 0;
            set_ovf = 1'b0;
            sets_sent++;
        end
    endtask

    // Sends one request; the line stays valid into the next request unless a gap is due.
    task automatic send_point(int x, int y, bit lp);
        int gap;
        pts.valid <= 1'b1;
        pts.point_x <= x[CW-1:0];
        pts.point_y <= y[CW-1:0];
        pts.last_point <= lp;
        do
            @(posedge clk);
        while (!pts.ready);
        predict_point(x[CW-1:0], y[CW-1:0], lp);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pts.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin
        vertex_t v;
        if (rst_n && hl.valid && hl.ready)
        begin
            vertices_seen++;
            if (hull_due.size() == 0)
                report("unexpected vertex x", 0, hl.hull_x);
            else
            begin
                v = hull_due.pop_front();
                if (hl.hull_x !== v.x)
                    report("hull_x", v.x, hl.hull_x);
                if (hl.hull_y !== v.y)
                    report("hull_y", v.y, hl.hull_y);
                if (hl.last_vertex !== v.lst)
                    report("last_vertex", v.lst, hl.last_vertex);
                if (hl.hull_count !== v.cnt)
                    report("hull_count", v.cnt, hl.hull_count);
                if (hl.overflowed !== v.ovf)
                    report("overflowed", v.ovf, hl.overflowed);
            end
        end
        rx_cycle++;
        case ((rx_cycle / 97) % 3)
            0: hl.ready <= 1'b1;
            1: hl.ready <= ($urandom_range(0, 2) != 0);
            default: hl.ready <= ((rx_cycle % 7) < 3);
        endcase
    end

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 8) * 256 - 1024;
            1: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        int mx;
        int mn;
        mx = 8388607;
        mn = -8388608;
        send_point(mx, mx, 1);
        send_point(mn, mn, 0);
        send_point(mx, mx, 1);
        send_point(0, 0, 0);
        send_point(256, 0, 0);
        send_point(0, 256, 0);
        send_point(0, 0, 1);
        send_point(0, 0, 0);
        send_point(512, 512, 0);
        send_point(256, 256, 0);
        send_point(768, 768, 1);
        send_point(0, 0, 0);
        send_point(512, 0, 0);
        send_point(256, 0, 0);
        send_point(512, 512, 0);
        send_point(0, 512, 0);
        send_point(0, 256, 0);
        send_point(256, 256, 0);
        send_point(1024, 1024, 1);
        send_point(mn, mn, 0);
        send_point(mx, mn, 0);
        send_point(mn, mx, 0);
        send_point(mx, mx, 1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < NPTS + 2; i++)
            send_point(i * 300 - 9000, (i * i * 37) % 5000, i == NPTS + 1);
    endtask

    task automatic test_random();
        int size;
        int mode;
        while (items_sent < 200)
        begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < size; i++)
                send_point(rand_coord(mode), rand_coord(mode), i == size - 1);
        end
    endtask

    initial
    begin
        pts.valid = 1'b0;
        pts.point_x = '0;
        pts.point_y = '0;
        pts.last_point = 1'b0;
        hl.ready = 1'b0;
        set_size = 0;
        set_ovf = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random();
        pts.valid <= 1'b0;
        while (hull_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d points in %0d sets, checked %0d hull vertices, %0d mismatches.",
                 items_sent, sets_sent, vertices_seen, errors);
        if (errors == 0)
            $display("tb_convex_hull_graham_scan OK");
        else
            $display("tb_convex_hull_graham_scan NOT OK");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("Timed out with %0d vertices outstanding.", hull_due.size());
        $display("tb_convex_hull_graham_scan NOT OK");
        $finish;
    end

endmodule
